// File: design/cube_tile_to_equirect_coord_assert.svh
// assertion macros for the cube tile to equirect block
// no dependencies
`ifndef CUBE_TILE_TO_EQUIRECT_COORD_ASSERT_SVH
`define CUBE_TILE_TO_EQUIRECT_COORD_ASSERT_SVH

// antecedent implies consequent on the same edge
`define CTEC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctec check failed");

// condition never holds out of reset
`define CTEC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ctec check failed");

`endif

// File: design/ctec_pkg.sv
// package for cube_tile_to_equirect_coord: types, constants, tables, helpers
// no dependencies
package ctec_pkg;

    localparam int MAX_FACE_SIZE   = 4096;
    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_W           = COORD_FRAC_BITS + 1;
    localparam int ITERS           = 30;
    localparam int SQ_BITS         = 26;
    localparam int N_W             = 2 * SQ_BITS;
    localparam int LAT             = 3 + SQ_BITS + ITERS;

    localparam logic [1:0] LEVEL_WHOLE   = 2'd0;
    localparam logic [1:0] LEVEL_QUARTER = 2'd1;
    localparam logic [1:0] LEVEL_SIXTEEN = 2'd2;

    localparam logic REG_FACE_SIZE  = 1'b0;
    localparam logic REG_TILE_LEVEL = 1'b1;

    typedef logic signed [51:0] t_cw;
    typedef logic signed [35:0] t_ang;
    typedef logic signed [15:0] t_dir;
    typedef logic signed [1:0]  t_coef;
    typedef t_coef [2:0][2:0]   t_basis;

    localparam t_ang HALF_TURN    = 36'sd2147483648;
    localparam t_ang QUARTER_TURN = 36'sd1073741824;

    localparam t_ang ATAN_TAB [ITERS] = '{
        36'sd536870912, 36'sd316933406, 36'sd167458907, 36'sd85004756, 36'sd42667331,
        36'sd21354465, 36'sd10679838, 36'sd5340245, 36'sd2670163, 36'sd1335087,
        36'sd667544, 36'sd333772, 36'sd166886, 36'sd83443, 36'sd41722, 36'sd20861,
        36'sd10430, 36'sd5215, 36'sd2608, 36'sd1304, 36'sd652, 36'sd326, 36'sd163,
        36'sd81, 36'sd41, 36'sd20, 36'sd10, 36'sd5, 36'sd3, 36'sd1
    };

    typedef struct packed {
        logic [2:0]  face;
        logic [1:0]  quadrant;
        logic [1:0]  sub_quadrant;
        logic [11:0] col;
        logic [11:0] row;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] u_coord;
        logic [OUT_W-1:0] v_coord;
    } t_out;

    typedef struct packed {
        t_dir dx;
        t_dir dy;
        t_dir dz;
    } t_vec;

    typedef struct packed {
        t_cw  x;
        t_cw  y;
        t_ang z;
        t_ang base;
        logic spec;
    } t_cordic_st;

    // rows: centre, axis x, axis y; columns: x, y, z component
    function automatic t_basis face_basis(input logic [2:0] face);
        t_basis b;
        b = '0;
        case (face)
            3'd0: begin
                b[0][0] = 2'sd1;  b[1][1] = 2'sd1;  b[2][2] = 2'sd1;
            end
            3'd1: begin
                b[0][0] = -2'sd1; b[1][1] = -2'sd1; b[2][2] = 2'sd1;
            end
            3'd2: begin
                b[0][1] = 2'sd1;  b[1][0] = -2'sd1; b[2][2] = 2'sd1;
            end
            3'd3: begin
                b[0][1] = -2'sd1; b[1][0] = 2'sd1;  b[2][2] = 2'sd1;
            end
            3'd4: begin
                b[0][2] = 2'sd1;  b[1][1] = 2'sd1;  b[2][0] = -2'sd1;
            end
            3'd5: begin
                b[0][2] = -2'sd1; b[1][1] = 2'sd1;  b[2][0] = 2'sd1;
            end
            default: begin
                b[0][1] = 2'sd1;  b[1][0] = 2'sd1;  b[2][2] = 2'sd1;
            end
        endcase
        return b;
    endfunction

    function automatic logic signed [16:0] coef_term(input logic signed [16:0] v,
                                                     input t_coef c);
        logic signed [16:0] r;
        r = '0;
        if (c == 2'sd1) begin
            r = v;
        end else if (c == -2'sd1) begin
            r = -v;
        end
        return r;
    endfunction

    // special cases and left half-plane fold ahead of the vectoring cells
    function automatic t_cordic_st cordic_pre(input t_cw x, input t_cw y);
        t_cordic_st st;
        st.x    = x;
        st.y    = y;
        st.z    = '0;
        st.base = '0;
        st.spec = 1'b0;
        if (y == '0) begin
            st.spec = 1'b1;
            st.base = (x < 0) ? HALF_TURN : '0;
        end else if (x == '0) begin
            st.spec = 1'b1;
            st.base = (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
        end else if (x < 0) begin
            st.base = (y > 0) ? HALF_TURN : -HALF_TURN;
            st.x    = -x;
            st.y    = -y;
        end
        return st;
    endfunction

    function automatic t_ang cordic_angle(input t_cordic_st st);
        return st.spec ? st.base : st.base + st.z;
    endfunction

    function automatic logic [OUT_W-1:0] to_coord(input t_ang a, input logic dbl);
        logic signed [39:0] t;
        logic signed [39:0] full;
        full = 40'sd1 <<< 32;
        t = 40'sd2147483648 + (dbl ? (40'(a) <<< 1) : 40'(a));
        if (t < 0) begin
            t = '0;
        end
        if (t > full) begin
            t = full;
        end
        t = t + (40'sd1 <<< (31 - COORD_FRAC_BITS));
        return t[32-COORD_FRAC_BITS +: OUT_W];
    endfunction

endpackage

// File: design/cube_tile_to_equirect_coord.sv
// top level: cube tile pixel to equirectangular u/v coordinate
// depends on ctec_pkg, ctec_dir_gen, ctec_sqrt_cell, ctec_cordic_cell
// A transaction is taken on every cycle in which i_start is high; o_busy is never raised. Each
// result appears on o_result with o_valid high for one cycle and cannot be held off: it passes
// the direction register, the squared-radius register, 26 square-root cells giving one root bit
// each, 30 cordic cells running the two angles side by side, and the coordinate register. The
// user must make register writes between bursts; the block takes them at once, unchecked.
module cube_tile_to_equirect_coord (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  ctec_pkg::t_in  i_item,
    output logic           o_valid,
    output ctec_pkg::t_out o_result,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_idx,
    input  logic [12:0]    i_cfg_wdata
);

    localparam int SB = ctec_pkg::SQ_BITS;
    localparam int IT = ctec_pkg::ITERS;

    logic [12:0]                r_face_size;
    logic [1:0]                 r_tile_level;
    logic [ctec_pkg::LAT-1:0]   r_vld;
    ctec_pkg::t_vec             w_dir;
    ctec_pkg::t_vec             r_dir2;
    logic [ctec_pkg::N_W-1:0]   r_n;
    logic [27:0]                w_rr;
    logic [ctec_pkg::N_W-1:0]   w_rem [SB+1];
    logic [SB-1:0]              w_root [SB+1];
    ctec_pkg::t_vec             w_sdir [SB+1];
    ctec_pkg::t_cordic_st       w_c1 [IT+1];
    ctec_pkg::t_cordic_st       w_c2 [IT+1];
    ctec_pkg::t_out             r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size  <= 13'd1024;
            r_tile_level <= ctec_pkg::LEVEL_WHOLE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                ctec_pkg::REG_FACE_SIZE:  r_face_size  <= i_cfg_wdata;
                ctec_pkg::REG_TILE_LEVEL: r_tile_level <= i_cfg_wdata[1:0];
                default:                  r_face_size  <= r_face_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ctec_pkg::LAT-2:0], i_start};
        end
    end

    ctec_dir_gen u_dir (
        .i_clk        (i_clk),
        .i_face_size  (r_face_size),
        .i_tile_level (r_tile_level),
        .i_item       (i_item),
        .o_dir        (w_dir)
    );

    assign w_rr = 28'(32'(w_dir.dx) * 32'(w_dir.dx)) + 28'(32'(w_dir.dy) * 32'(w_dir.dy));

    always_ff @(posedge i_clk) begin
        r_n    <= {w_rr[27:0], 24'd0};
        r_dir2 <= w_dir;
    end

    assign w_rem[0]  = r_n;
    assign w_root[0] = '0;
    assign w_sdir[0] = r_dir2;

    for (genvar g = 0; g < SB; g++) begin : g_sqrt
        ctec_sqrt_cell #(.K(SB - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .i_dir  (w_sdir[g]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1]),
            .o_dir  (w_sdir[g+1])
        );
    end

    assign w_c1[0] = ctec_pkg::cordic_pre(ctec_pkg::t_cw'(w_sdir[SB].dx) <<< 32,
                                          ctec_pkg::t_cw'(w_sdir[SB].dy) <<< 32);
    assign w_c2[0] = ctec_pkg::cordic_pre(ctec_pkg::t_cw'({1'b0, w_root[SB]}) <<< 20,
                                          ctec_pkg::t_cw'(w_sdir[SB].dz) <<< 32);

    for (genvar g = 0; g < IT; g++) begin : g_cordic
        ctec_cordic_cell #(.I(g)) u_lon (
            .i_clk (i_clk),
            .i_st  (w_c1[g]),
            .o_st  (w_c1[g+1])
        );
        ctec_cordic_cell #(.I(g)) u_lat (
            .i_clk (i_clk),
            .i_st  (w_c2[g]),
            .o_st  (w_c2[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_out.u_coord <= ctec_pkg::to_coord(ctec_pkg::cordic_angle(w_c1[IT]), 1'b0);
        r_out.v_coord <= ctec_pkg::to_coord(ctec_pkg::cordic_angle(w_c2[IT]), 1'b1);
    end

    assign o_busy   = 1'b0;
    assign o_valid  = r_vld[ctec_pkg::LAT-1];
    assign o_result = r_out;

endmodule

// File: design/ctec_dir_gen.sv
// front cell: tile pixel to integer direction vector, one transaction a cycle
// depends on ctec_pkg
module ctec_dir_gen (
    input  logic              i_clk,
    input  logic [12:0]       i_face_size,
    input  logic [1:0]        i_tile_level,
    input  ctec_pkg::t_in     i_item,
    output ctec_pkg::t_vec    o_dir
);

    logic [12:0]        w_fs;
    logic signed [16:0] w_s, w_col, w_row, w_cs, w_p, w_q;
    logic signed [16:0] w_po, w_qo;
    logic               w_kx_q, w_ky_q, w_kx_s, w_ky_s;
    ctec_pkg::t_basis   w_b;
    logic signed [16:0] w_d [3];
    ctec_pkg::t_vec     r_dir;

    always_comb begin
        if (i_face_size < 13'd2) begin
            w_fs = 13'd2;
        end else if (i_face_size > 13'(ctec_pkg::MAX_FACE_SIZE)) begin
            w_fs = 13'(ctec_pkg::MAX_FACE_SIZE);
        end else begin
            w_fs = i_face_size;
        end
        w_s   = 17'(w_fs) - 17'sd1;
        w_col = 17'(i_item.col);
        w_row = 17'(i_item.row);
        w_kx_q = (i_item.quadrant == 2'd0) || (i_item.quadrant == 2'd3);
        w_ky_q = (i_item.quadrant == 2'd0) || (i_item.quadrant == 2'd1);
        w_kx_s = (i_item.sub_quadrant == 2'd0) || (i_item.sub_quadrant == 2'd3);
        w_ky_s = (i_item.sub_quadrant == 2'd0) || (i_item.sub_quadrant == 2'd1);
        w_po = w_kx_s ? w_col : w_col - w_s;
        w_qo = w_ky_s ? w_row : w_row - w_s;
        case (i_tile_level)
            ctec_pkg::LEVEL_WHOLE: begin
                w_cs = w_s;
                w_p  = (w_col <<< 1) - w_s;
                w_q  = (w_row <<< 1) - w_s;
            end
            ctec_pkg::LEVEL_QUARTER: begin
                w_cs = w_s;
                w_p  = w_kx_q ? w_col : w_col - w_s;
                w_q  = w_ky_q ? w_row : w_row - w_s;
            end
            ctec_pkg::LEVEL_SIXTEEN: begin
                w_cs = w_s <<< 1;
                w_p  = (w_kx_q ? w_s : -w_s) + w_po;
                w_q  = (w_ky_q ? w_s : -w_s) + w_qo;
            end
            default: begin
                w_cs = 17'sd1;
                w_p  = '0;
                w_q  = '0;
            end
        endcase
        w_b = ctec_pkg::face_basis(i_item.face);
        for (int k = 0; k < 3; k++) begin
            w_d[k] = ctec_pkg::coef_term(w_cs, w_b[0][k])
                   + ctec_pkg::coef_term(w_p, w_b[1][k])
                   + ctec_pkg::coef_term(w_q, w_b[2][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir.dx <= w_d[0][15:0];
        r_dir.dy <= w_d[1][15:0];
        r_dir.dz <= w_d[2][15:0];
    end

    assign o_dir = r_dir;

endmodule

// File: design/ctec_sqrt_cell.sv
// one root bit of the pipelined integer square root, carries the direction along
// depends on ctec_pkg
module ctec_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                          i_clk,
    input  logic [ctec_pkg::N_W-1:0]      i_rem,
    input  logic [ctec_pkg::SQ_BITS-1:0]  i_root,
    input  ctec_pkg::t_vec                i_dir,
    output logic [ctec_pkg::N_W-1:0]      o_rem,
    output logic [ctec_pkg::SQ_BITS-1:0]  o_root,
    output ctec_pkg::t_vec                o_dir
);

    logic [ctec_pkg::N_W+1:0]     w_test;
    logic [ctec_pkg::N_W-1:0]     r_rem;
    logic [ctec_pkg::SQ_BITS-1:0] r_root;
    ctec_pkg::t_vec               r_dir;

    assign w_test = ((ctec_pkg::N_W+2)'(i_root) << (K + 1))
                  + ((ctec_pkg::N_W+2)'(1) << (2 * K));

    always_ff @(posedge i_clk) begin
        r_dir <= i_dir;
        if ((ctec_pkg::N_W+2)'(i_rem) >= w_test) begin
            r_rem  <= i_rem - w_test[ctec_pkg::N_W-1:0];
            r_root <= i_root | (ctec_pkg::SQ_BITS'(1) << K);
        end else begin
            r_rem  <= i_rem;
            r_root <= i_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_dir  = r_dir;

endmodule

// File: design/ctec_cordic_cell.sv
// one vectoring step of the angle cordic
// depends on ctec_pkg
module ctec_cordic_cell #(
    parameter int I = 0
) (
    input  logic                 i_clk,
    input  ctec_pkg::t_cordic_st i_st,
    output ctec_pkg::t_cordic_st o_st
);

    ctec_pkg::t_cordic_st r_st;

    always_ff @(posedge i_clk) begin
        r_st.base <= i_st.base;
        r_st.spec <= i_st.spec;
        if (i_st.y > 0) begin
            r_st.x <= i_st.x + (i_st.y >>> I);
            r_st.y <= i_st.y - (i_st.x >>> I);
            r_st.z <= i_st.z + ctec_pkg::ATAN_TAB[I];
        end else begin
            r_st.x <= i_st.x - (i_st.y >>> I);
            r_st.y <= i_st.y + (i_st.x >>> I);
            r_st.z <= i_st.z - ctec_pkg::ATAN_TAB[I];
        end
    end

    assign o_st = r_st;

endmodule

// File: design/ctec_checker.sv
// port-level checks for cube_tile_to_equirect_coord, bound to the top level
// depends on ctec_pkg and cube_tile_to_equirect_coord_assert.svh
`include "cube_tile_to_equirect_coord_assert.svh"

module ctec_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_valid,
    input ctec_pkg::t_out o_result
);

    localparam logic [ctec_pkg::OUT_W-1:0] ONE = ctec_pkg::OUT_W'(1) << ctec_pkg::COORD_FRAC_BITS;

    `CTEC_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, o_busy)
    `CTEC_ASSERT_IMPLY(a_valid_has_transaction, i_clk, i_rst_n, o_valid, $past(i_start, ctec_pkg::LAT))
    `CTEC_ASSERT_IMPLY(a_u_range, i_clk, i_rst_n, o_valid, o_result.u_coord <= ONE)
    `CTEC_ASSERT_IMPLY(a_v_range, i_clk, i_rst_n, o_valid, o_result.v_coord <= ONE)

endmodule

bind cube_tile_to_equirect_coord ctec_checker u_ctec_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// File: tb/sv/cube_tile_to_equirect_coord_check.sv
// checker for cube_tile_to_equirect_coord: predicts u/v for every accepted transaction
// and compares results in order; depends on ctec_pkg
`timescale 1ns / 100ps

module cube_tile_to_equirect_coord_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  ctec_pkg::t_in   i_item,
    input  logic            i_valid,
    input  ctec_pkg::t_out  i_result,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_idx,
    input  logic [12:0]     i_cfg_wdata,
    output int              o_errors,
    output int              o_pending
);

    // per face: centre xyz, axis x xyz, axis y xyz
    localparam int FACE_AXES [8][9] = '{
        '{ 1, 0, 0,  0, 1, 0,  0, 0, 1},
        '{-1, 0, 0,  0,-1, 0,  0, 0, 1},
        '{ 0, 1, 0, -1, 0, 0,  0, 0, 1},
        '{ 0,-1, 0,  1, 0, 0,  0, 0, 1},
        '{ 0, 0, 1,  0, 1, 0, -1, 0, 0},
        '{ 0, 0,-1,  0, 1, 0,  1, 0, 0},
        '{ 0, 1, 0,  1, 0, 0,  0, 0, 1},
        '{ 0, 1, 0,  1, 0, 0,  0, 0, 1}
    };
    localparam longint ARC_STEP [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic [12:0]     face_size_q;
    logic [1:0]      level_q;
    ctec_pkg::t_out  coord_queue [$];

    function automatic longint vector_angle(input longint x, input longint y);
        longint base;
        longint z;
        longint nx;
        base = 0;
        z = 0;
        if (y == 0) return (x < 0) ? 64'sd2147483648 : 0;
        if (x == 0) return (y > 0) ? 64'sd1073741824 : -64'sd1073741824;
        if (x < 0) begin
            base = (y > 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        x = x * 1048576;
        y = y * 1048576;
        for (int i = 0; i < 30; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARC_STEP[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARC_STEP[i];
            end
            x = nx;
        end
        return base + z;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [ctec_pkg::OUT_W-1:0] turn_to_coord(input longint t);
        if (t < 0) t = 0;
        if (t > 64'sd4294967296) t = 64'sd4294967296;
        t = (t + (64'sd1 << (31 - ctec_pkg::COORD_FRAC_BITS)))
            >>> (32 - ctec_pkg::COORD_FRAC_BITS);
        return t[ctec_pkg::OUT_W-1:0];
    endfunction

    function automatic longint plane_shift(input logic [1:0] sel, input longint pos,
                                           input longint s, input bit is_x);
        bit keep;
        keep = is_x ? (sel == 0 || sel == 3) : (sel == 0 || sel == 1);
        return keep ? pos : pos - s;
    endfunction

    function automatic ctec_pkg::t_out equirect_coord(input ctec_pkg::t_in it,
                                                      input logic [12:0] fs_reg,
                                                      input logic [1:0] lvl);
        longint          fs, s, cs, p, q, a, r;
        longint          d [3];
        int              f;
        ctec_pkg::t_out  res;
        fs = fs_reg;
        if (fs < 2) fs = 2;
        if (fs > ctec_pkg::MAX_FACE_SIZE) fs = ctec_pkg::MAX_FACE_SIZE;
        s = fs - 1;
        f = it.face;
        case (lvl)
            ctec_pkg::LEVEL_WHOLE: begin
                cs = s;
                p = 2 * longint'(it.col) - s;
                q = 2 * longint'(it.row) - s;
            end
            ctec_pkg::LEVEL_QUARTER: begin
                cs = s;
                p = plane_shift(it.quadrant, it.col, s, 1);
                q = plane_shift(it.quadrant, it.row, s, 0);
            end
            ctec_pkg::LEVEL_SIXTEEN: begin
                cs = 2 * s;
                p = ((it.quadrant == 0 || it.quadrant == 3) ? s : -s)
                    + plane_shift(it.sub_quadrant, it.col, s, 1);
                q = ((it.quadrant == 0 || it.quadrant == 1) ? s : -s)
                    + plane_shift(it.sub_quadrant, it.row, s, 0);
            end
            default: begin
                cs = 1;
                p = 0;
                q = 0;
            end
        endcase
        for (int k = 0; k < 3; k++)
            d[k] = cs * FACE_AXES[f][k] + p * FACE_AXES[f][3+k] + q * FACE_AXES[f][6+k];
        a = vector_angle(d[0] * 4096, d[1] * 4096);
        res.u_coord = turn_to_coord(64'sd2147483648 + a);
        r = root_floor(longint'(d[0] * d[0] + d[1] * d[1]) << 24);
        a = vector_angle(r, d[2] * 4096);
        res.v_coord = turn_to_coord(64'sd2147483648 + 2 * a);
        return res;
    endfunction

    always @(posedge i_clk) begin
        ctec_pkg::t_out want;
        int             errs;
        errs = 0;
        if (!i_rst_n) begin
            face_size_q <= 13'd1024;
            level_q     <= ctec_pkg::LEVEL_WHOLE;
            coord_queue.delete();
            o_errors    <= 0;
            o_pending   <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == ctec_pkg::REG_FACE_SIZE) face_size_q <= i_cfg_wdata;
                else level_q <= i_cfg_wdata[1:0];
            end
            if (i_valid) begin
                if (coord_queue.size() == 0) begin
                    $error("result with no transaction waiting");
                    errs++;
                end else begin
                    want = coord_queue.pop_front();
                    if (want.u_coord !== i_result.u_coord) begin
                        $error("u_coord expected %0d actual %0d", want.u_coord,
                               i_result.u_coord);
                        errs++;
                    end
                    if (want.v_coord !== i_result.v_coord) begin
                        $error("v_coord expected %0d actual %0d", want.v_coord,
                               i_result.v_coord);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy)
                coord_queue.insert(coord_queue.size(),
                                   equirect_coord(i_item, face_size_q, level_q));
            o_errors  <= o_errors + errs;
            o_pending <= coord_queue.size();
        end
    end
endmodule

// File: tb/sv/cube_tile_to_equirect_coord_test.sv
// testbench top for cube_tile_to_equirect_coord: drives transactions and register writes
// depends on ctec_pkg, the block and cube_tile_to_equirect_coord_check
`timescale 1ns / 100ps

module cube_tile_to_equirect_coord_test;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    ctec_pkg::t_in   item;
    logic            valid;
    ctec_pkg::t_out  result;
    logic            cfg_wr_en;
    logic            cfg_idx;
    logic [12:0]     cfg_wdata;
    int              errors;
    int              pending;
    logic [12:0]     cur_size;

    cube_tile_to_equirect_coord u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy), .i_item(item),
        .o_valid(valid), .o_result(result), .i_cfg_wr_en(cfg_wr_en), .i_cfg_idx(cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    cube_tile_to_equirect_coord_check u_check (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_item(item),
        .i_valid(valid), .i_result(result), .i_cfg_wr_en(cfg_wr_en), .i_cfg_idx(cfg_idx),
        .i_cfg_wdata(cfg_wdata), .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (ctec_pkg::LAT + 10) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // caller is at a falling edge; returns at the falling edge after acceptance
    task automatic push_pixel(input ctec_pkg::t_in it);
        start = 1'b1;
        item  = it;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic ctec_pkg::t_in random_pixel();
        ctec_pkg::t_in it;
        it.face         = 3'($urandom_range(7, 0));
        it.quadrant     = 2'($urandom_range(3, 0));
        it.sub_quadrant = 2'($urandom_range(3, 0));
        if ($urandom_range(9, 0) == 0) begin
            it.col = 12'($urandom);
            it.row = 12'($urandom);
        end else begin
            it.col = 12'($urandom_range(cur_size > 4096 ? 4095 : cur_size - 1, 0));
            it.row = 12'($urandom_range(cur_size > 4096 ? 4095 : cur_size - 1, 0));
        end
        return it;
    endfunction

    task automatic random_run(input int n);
        int left;
        int burst;
        left = n;
        @(negedge clk);
        while (left > 0) begin
            burst = $urandom_range(20, 1);
            while (burst > 0 && left > 0) begin
                push_pixel(random_pixel());
                burst--;
                left--;
            end
            start = 1'b0;
            if ($urandom_range(3, 0) != 0) repeat ($urandom_range(6, 1)) @(negedge clk);
        end
        start = 1'b0;
    endtask

    task automatic directed_run();
        ctec_pkg::t_in it;
        @(negedge clk);
        for (int f = 0; f < 8; f++) begin
            it = '{face: 3'(f), quadrant: 2'd0, sub_quadrant: 2'd0, col: 12'd1, row: 12'd1};
            push_pixel(it);
        end
        for (int k = 0; k < 4; k++) begin
            it = '{face: 3'd0, quadrant: 2'(k), sub_quadrant: 2'(3 - k),
                   col: (k[0] ? 12'd2 : 12'd0), row: (k[1] ? 12'd2 : 12'd0)};
            push_pixel(it);
        end
        it = '{face: 3'd7, quadrant: 2'd3, sub_quadrant: 2'd3, col: 12'hFFF, row: 12'hFFF};
        push_pixel(it);
        it = '{face: 3'd1, quadrant: 2'd0, sub_quadrant: 2'd0, col: 12'd1, row: 12'd0};
        push_pixel(it);
        it = '{face: 3'd5, quadrant: 2'd1, sub_quadrant: 2'd2, col: 12'hFFF, row: 12'd0};
        push_pixel(it);
        start = 1'b0;
    endtask

    initial begin
        logic [12:0] sizes [12];
        logic [1:0]  levels [12];
        sizes  = '{13'd3, 13'd2, 13'd4096, 13'd1024, 13'd0, 13'd8191,
                   13'd17, 13'd5000, 13'd255, 13'd1, 13'd4095, 13'd64};
        levels = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2,
                   2'd2, 2'd0, 2'd1, 2'd3, 2'd0, 2'd2};
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_wr_en = 1'b0;
        cfg_idx = ctec_pkg::REG_FACE_SIZE;
        cfg_wdata = '0;
        cur_size = 13'd1024;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        random_run(40);
        drain();
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(ctec_pkg::REG_FACE_SIZE, sizes[ph]);
            write_reg(ctec_pkg::REG_TILE_LEVEL, 13'(levels[ph]));
            cur_size = (sizes[ph] < 2) ? 13'd2 : sizes[ph];
            if (ph == 0) directed_run();
            random_run(140);
            drain();
        end
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
